/* src/kst_pkg.sv */
// Package with the shared types and constants of the keyed set table.
`timescale 1ns / 1ps

package kst_pkg;

    // Fixed field widths of the transfer ports.
    localparam int KEY_W       = 32;
    localparam int EXT_HANDLE_W = 16;
    localparam int COUNT_OUT_W = 5;

    // Operation codes carried by the kind field.
    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_LOOKUP = 2'd2,
        KIND_POP    = 2'd3
    } t_kind;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_PRESENT   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_POP_DATA,
        S_MOVE,
        S_RESP
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;        // capture the input transfer and restart the scan
        logic    scan_step;   // issue the next scan read
        logic    rd_last;     // read the entry in the last occupied slot
        logic    dec_count;   // drop the entry count by one
        logic    append;      // write the new entry after the last one
        logic    move_wr;     // write the read entry into the found slot
        logic    take_data;   // latch the read entry as the result
        logic    set_status;  // latch the status below
        t_status status;
        logic    out_load;    // move the result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_kind kind;
        logic  count_zero;
        logic  full;
        logic  hit;
        logic  miss;
        logic  out_free;
    } t_sts;

endpackage

/* src/kst_ctrl.sv */
// Controller state machine that sequences each operation of the keyed set table.
`timescale 1ns / 1ps

module kst_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  kst_pkg::t_sts i_sts,
    output kst_pkg::t_cmd o_cmd
);

    kst_pkg::t_state r_state;
    kst_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kst_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Input transfers are taken only while no operation is in progress.
    assign o_in_stall = (r_state != kst_pkg::S_IDLE);

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.status = kst_pkg::ST_DONE;
        unique case (r_state)
            kst_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = kst_pkg::S_DECODE;
                end
            end
            kst_pkg::S_DECODE: begin
                if (i_sts.kind == kst_pkg::KIND_POP) begin
                    if (i_sts.count_zero) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = kst_pkg::ST_EMPTY;
                        n_state          = kst_pkg::S_RESP;
                    end else begin
                        o_cmd.rd_last   = 1'b1;
                        o_cmd.dec_count = 1'b1;
                        n_state         = kst_pkg::S_POP_DATA;
                    end
                end else begin
                    o_cmd.scan_step = 1'b1;
                    n_state         = kst_pkg::S_SCAN;
                end
            end
            kst_pkg::S_SCAN: begin
                priority if (i_sts.hit) begin
                    o_cmd.set_status = 1'b1;
                    n_state          = kst_pkg::S_RESP;
                    unique case (i_sts.kind)
                        kst_pkg::KIND_ADD: begin
                            o_cmd.status = kst_pkg::ST_PRESENT;
                        end
                        kst_pkg::KIND_REMOVE: begin
                            o_cmd.take_data = 1'b1;
                            o_cmd.dec_count = 1'b1;
                            o_cmd.rd_last   = 1'b1;
                            n_state         = kst_pkg::S_MOVE;
                        end
                        default: begin
                            o_cmd.take_data = 1'b1;
                        end
                    endcase
                end else if (i_sts.miss) begin
                    o_cmd.set_status = 1'b1;
                    n_state          = kst_pkg::S_RESP;
                    if (i_sts.kind == kst_pkg::KIND_ADD) begin
                        if (i_sts.full) begin
                            o_cmd.status = kst_pkg::ST_FULL;
                        end else begin
                            o_cmd.append = 1'b1;
                        end
                    end else begin
                        o_cmd.status = kst_pkg::ST_NOT_FOUND;
                    end
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            kst_pkg::S_POP_DATA: begin
                o_cmd.take_data  = 1'b1;
                o_cmd.set_status = 1'b1;
                n_state          = kst_pkg::S_RESP;
            end
            kst_pkg::S_MOVE: begin
                o_cmd.move_wr = 1'b1;
                n_state       = kst_pkg::S_RESP;
            end
            kst_pkg::S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = kst_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = kst_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* src/kst_dp.sv */
// Datapath of the keyed set table: entry memory, count, scan pointer and result registers.
`timescale 1ns / 1ps

module kst_dp #(
    parameter int CAPACITY    = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  kst_pkg::t_cmd                          i_cmd,
    output kst_pkg::t_sts                          o_sts,
    input  logic [1:0]                             i_kind,
    input  logic signed [kst_pkg::KEY_W-1:0]       i_key,
    input  logic [kst_pkg::EXT_HANDLE_W-1:0]       i_entry_handle,
    input  logic                                   i_out_stall,
    output logic                                   o_out_valid,
    output logic [2:0]                             o_status,
    output logic signed [kst_pkg::KEY_W-1:0]       o_out_key,
    output logic [kst_pkg::EXT_HANDLE_W-1:0]       o_out_handle,
    output logic [kst_pkg::COUNT_OUT_W-1:0]        o_entry_count
);

    localparam int AW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int WORD_W = kst_pkg::KEY_W + HANDLE_BITS;

    // Entry memory: key in the upper bits, handle in the lower bits.
    logic [WORD_W-1:0]               r_mem [CAPACITY];
    logic [WORD_W-1:0]               r_rd_data;

    logic [CW-1:0]                   r_count;
    logic [CW-1:0]                   r_idx;
    logic                            r_rd_vld;
    logic [AW-1:0]                   r_rd_idx;
    logic [AW-1:0]                   r_slot;
    kst_pkg::t_kind                  r_kind;
    logic [kst_pkg::KEY_W-1:0]       r_key;
    logic [HANDLE_BITS-1:0]          r_handle;

    kst_pkg::t_status                r_res_status;
    logic [kst_pkg::KEY_W-1:0]       r_res_key;
    logic [HANDLE_BITS-1:0]          r_res_handle;

    logic                            r_out_vld;
    kst_pkg::t_status                r_out_status;
    logic [kst_pkg::KEY_W-1:0]       r_out_key;
    logic [kst_pkg::EXT_HANDLE_W-1:0] r_out_handle;
    logic [kst_pkg::COUNT_OUT_W-1:0] r_out_count;

    logic [CW-1:0]                   w_last;
    logic [AW-1:0]                   w_rd_addr;
    logic [HANDLE_BITS+kst_pkg::EXT_HANDLE_W-1:0] w_in_handle_ext;
    logic [HANDLE_BITS+kst_pkg::EXT_HANDLE_W-1:0] w_res_handle_ext;
    logic [CW+kst_pkg::COUNT_OUT_W-1:0]           w_count_ext;
    logic                            w_match;
    logic                            w_out_free;

    // Width adaption of the handle and the count.
    assign w_in_handle_ext  = {{HANDLE_BITS{1'b0}}, i_entry_handle};
    assign w_res_handle_ext = {{kst_pkg::EXT_HANDLE_W{1'b0}}, r_res_handle};
    assign w_count_ext      = {{kst_pkg::COUNT_OUT_W{1'b0}}, r_count};

    // Read address: the last occupied slot or the scan pointer.
    assign w_last    = r_count - CW'(1);
    assign w_rd_addr = i_cmd.rd_last ? w_last[AW-1:0] : r_idx[AW-1:0];

    // Key compare on the entry read in the previous cycle.
    assign w_match    = (r_rd_data[WORD_W-1:HANDLE_BITS] == r_key);
    assign w_out_free = !r_out_vld || !i_out_stall;

    // Status towards the controller.
    always_comb begin
        o_sts.kind       = r_kind;
        o_sts.count_zero = (r_count == '0);
        o_sts.full       = (r_count == CW'(CAPACITY));
        o_sts.hit        = r_rd_vld && w_match;
        o_sts.miss       = !r_rd_vld && (r_idx >= r_count);
        o_sts.out_free   = w_out_free;
    end

    // Entry memory with one write port and a registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            r_mem[r_count[AW-1:0]] <= {r_key, r_handle};
        end else if (i_cmd.move_wr) begin
            r_mem[r_slot] <= r_rd_data;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // Entry count and scan control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.append) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.dec_count) begin
                r_count <= w_last;
            end
            if (i_cmd.load) begin
                r_idx    <= '0;
                r_rd_vld <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_rd_vld <= (r_idx < r_count);
                if (r_idx < r_count) begin
                    r_idx <= r_idx + CW'(1);
                end
            end
        end
    end

    // Input capture, scan slot tracking and result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step) begin
            r_rd_idx <= r_idx[AW-1:0];
        end
        if (i_cmd.load) begin
            r_kind       <= kst_pkg::t_kind'(i_kind);
            r_key        <= i_key;
            r_handle     <= w_in_handle_ext[HANDLE_BITS-1:0];
            r_res_key    <= '0;
            r_res_handle <= '0;
            r_res_status <= kst_pkg::ST_DONE;
        end else begin
            if (i_cmd.take_data) begin
                r_res_key    <= r_rd_data[WORD_W-1:HANDLE_BITS];
                r_res_handle <= r_rd_data[HANDLE_BITS-1:0];
                r_slot       <= r_rd_idx;
            end
            if (i_cmd.set_status) begin
                r_res_status <= i_cmd.status;
            end
        end
    end

    // Output register: holds the result until the receiver takes the transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_key    <= r_res_key;
            r_out_handle <= w_res_handle_ext[kst_pkg::EXT_HANDLE_W-1:0];
            r_out_count  <= w_count_ext[kst_pkg::COUNT_OUT_W-1:0];
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_status      = r_out_status;
    assign o_out_key     = r_out_key;
    assign o_out_handle  = r_out_handle;
    assign o_entry_count = r_out_count;

endmodule

/* src/keyed_set_table_unit.sv */
// Top level of the keyed set table: an unordered set of keyed entries searched linearly.
// Input channel: i_in_valid / o_in_stall carry one operation (kind, key, entry handle).
// An operation is taken when valid is high and stall is low; stall stays high until
// the result of that operation has been placed in the output register.
// Output channel: o_out_valid / i_out_stall carry one result per operation (status,
// key, handle and the entry count after the operation).
// Pop reads the entry in the last occupied slot and drops the count, then latches that
// entry as the result and loads the output register. Add, remove and lookup scan the
// stored keys one memory read per cycle until a hit or a miss; remove then moves the
// last entry into the freed slot. The single read port of the entry memory sets this
// scan rate; one operation is in progress at a time, so the next input transfer can be
// taken in the cycle after the result is loaded.
// The next operation may be taken while the previous result still waits in the
// output register; a stalled receiver only holds the next result back.
// Reset clears the entry count and both valid flags; memory contents need no reset.
`timescale 1ns / 1ps

module keyed_set_table_unit #(
    parameter int CAPACITY    = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [1:0]                       i_kind,
    input  logic signed [kst_pkg::KEY_W-1:0] i_key,
    input  logic [kst_pkg::EXT_HANDLE_W-1:0] i_entry_handle,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [2:0]                       o_status,
    output logic signed [kst_pkg::KEY_W-1:0] o_out_key,
    output logic [kst_pkg::EXT_HANDLE_W-1:0] o_out_handle,
    output logic [kst_pkg::COUNT_OUT_W-1:0]  o_entry_count
);

    kst_pkg::t_cmd w_cmd;
    kst_pkg::t_sts w_sts;

    // Operation sequencer.
    kst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Storage, compare and result path.
    kst_dp #(
        .CAPACITY    (CAPACITY),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_kind         (i_kind),
        .i_key          (i_key),
        .i_entry_handle (i_entry_handle),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_out_key      (o_out_key),
        .o_out_handle   (o_out_handle),
        .o_entry_count  (o_entry_count)
    );

endmodule
